FILE: sv/rfb_pkg.sv
// rfb_pkg: widths, constants and codes of the radial falloff blend
// no dependencies
`timescale 1ns / 1ps

package rfb_pkg;

  localparam int DIST_W   = 10;
  localparam int VAL_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_SHAPE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN    = 3'd3;

  localparam logic [7:0] RST_RADIUS_SQ     = 8'd2;
  localparam logic [7:0] RST_FALLOFF_SHAPE = 8'd64;
  localparam logic [7:0] RST_PRESENCE      = 8'd255;
  localparam logic [8:0] RST_BLEND_GAIN    = 9'd16;

  localparam logic [9:0]  EDGE_SQ  = 10'd225;
  localparam logic [11:0] CEIL_VAL = 12'd4095;
  localparam logic [7:0]  SHAPE_HALF = 8'd128;
  localparam logic [7:0]  SHAPE_FULL = 8'd255;

  // floor(y*800/16129) = (y*SHAPE_RECIP) >> SHAPE_SHIFT for y <= 16129
  localparam logic [23:0] SHAPE_RECIP = 24'd13314426;
  localparam int          SHAPE_SHIFT = 28;
  // floor(p/17) = (p*PRES_RECIP) >> 12 for p <= 255
  localparam logic [7:0]  PRES_RECIP = 8'd241;

  localparam int DIV_BITS = 12;
  localparam int NUM_W    = 31;
  localparam int DEN_W    = 19;
  localparam int SETTLE   = 3;

  // pipeline stage positions
  localparam int ST_S1  = 0;
  localparam int ST_S2  = 1;
  localparam int ST_S3  = 2;
  localparam int ST_S4  = 3;
  localparam int ST_V   = ST_S4 + DIV_BITS + 1;
  localparam int ST_B1  = ST_V + 1;
  localparam int ST_B2  = ST_V + 2;
  localparam int ST_B3  = ST_V + 3;
  localparam int ST_B4  = ST_V + 4;
  localparam int ST_OUT = ST_V + 5;
  localparam int NST    = ST_OUT + 1;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_CURVE = 2'd0;
  localparam sel_t SEL_PEAK  = 2'd1;
  localparam sel_t SEL_ZERO  = 2'd2;
  localparam sel_t SEL_SAT   = 2'd3;

endpackage

FILE: sv/rfb_in_if.sv
// rfb_in_if: pixel input channel, valid/ready plus payload
// depends on rfb_pkg
`timescale 1ns / 1ps

interface rfb_in_if import rfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] dist_sq;
  logic [VAL_W-1:0]  under_value;

  modport source (output valid, dist_sq, under_value, input ready);
  modport sink   (input valid, dist_sq, under_value, output ready);
endinterface

FILE: sv/rfb_out_if.sv
// rfb_out_if: result channel, valid/ready plus payload
// depends on rfb_pkg
`timescale 1ns / 1ps

interface rfb_out_if import rfb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] falloff_value;
  logic [VAL_W-1:0] blended_value;

  modport source (output valid, falloff_value, blended_value, input ready);
  modport sink   (input valid, falloff_value, blended_value, output ready);
endinterface

FILE: sv/rfb_cfg_if.sv
// rfb_cfg_if: register write channel, valid/ready plus index and data
// depends on rfb_pkg
`timescale 1ns / 1ps

interface rfb_cfg_if import rfb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/radial_falloff_blend.sv
// radial_falloff_blend: falloff curve and blend pipeline with config registers
// depends on rfb_pkg, rfb_in_if, rfb_out_if, rfb_cfg_if
`timescale 1ns / 1ps

// Takes one pixel beat per cycle unless held off by a full pipeline or by
// settling, and returns one result beat per pixel, in order. The depth is set
// by the curve divider, which resolves one quotient bit per stage over 12 stages,
// plus the multiply stages before it and the blend stages after it. Each stage
// holds its beat while the stage after it is full, so a stalled output does not
// block input until the pipeline has filled. After reset and after every register
// write, input is held off while the derived curve terms are recomputed; register
// writes are always taken.

module radial_falloff_blend import rfb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rfb_in_if.sink    in_pix,
  rfb_out_if.source out_pix,
  rfb_cfg_if.sink   cfg_wr
);

  // configuration registers
  logic [7:0]        radius_sq_r, falloff_shape_r, presence_r;
  logic signed [8:0] blend_gain_r;
  logic [1:0]        settle_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_sq_r     <= RST_RADIUS_SQ;
      falloff_shape_r <= RST_FALLOFF_SHAPE;
      presence_r      <= RST_PRESENCE;
      blend_gain_r    <= RST_BLEND_GAIN;
      settle_r        <= 2'(SETTLE);
    end else begin
      if (cfg_wr.valid) begin
        settle_r <= 2'(SETTLE);
        case (cfg_wr.index)
          REG_RADIUS_SQ:     radius_sq_r     <= cfg_wr.data[7:0];
          REG_FALLOFF_SHAPE: falloff_shape_r <= cfg_wr.data[7:0];
          REG_PRESENCE:      presence_r      <= cfg_wr.data[7:0];
          REG_BLEND_GAIN:    blend_gain_r    <= cfg_wr.data;
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // derived curve terms
  logic              fsel1_r, fsel2_r;
  logic [13:0]       ff_r;
  logic [7:0]        pres1_r;
  logic [9:0]        qd_r;
  logic [11:0]       peak_r;
  logic signed [12:0] c_r;
  logic [10:0]       a_r;
  logic [7:0]        d_r;
  logic [6:0]        fe;
  logic [37:0]       shape_prod;
  logic [15:0]       pres_prod;

  assign fe = (falloff_shape_r >= SHAPE_HALF) ? 7'(SHAPE_FULL - falloff_shape_r)
                                              : falloff_shape_r[6:0];
  assign shape_prod = 38'(ff_r) * 38'(SHAPE_RECIP);
  assign pres_prod  = 16'(pres1_r) * 16'(PRES_RECIP);

  always_ff @(posedge clk) begin
    fsel1_r <= (falloff_shape_r >= SHAPE_HALF);
    ff_r    <= 14'(fe) * 14'(fe);
    pres1_r <= presence_r;
    fsel2_r <= fsel1_r;
    qd_r    <= shape_prod[SHAPE_SHIFT +: 10];
    peak_r  <= {pres1_r, 4'b0000} + 12'(pres_prod[15:12]);
    if (fsel2_r) begin
      c_r <= 13'sd226 + $signed({3'b000, qd_r});
      a_r <= 11'(11'd226 + 11'(qd_r) - 11'(radius_sq_r));
    end else begin
      c_r <= $signed({5'b00000, radius_sq_r}) - 13'sd1 - $signed({3'b000, qd_r});
      a_r <= 11'(qd_r) + 11'd1;
    end
    d_r <= 8'(EDGE_SQ - 10'(radius_sq_r));
  end

  // stage handshake
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  logic           in_acc;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_pix.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_pix.ready = en[0] && (settle_r == 2'd0);
  assign in_acc       = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_acc;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // s1: region test and distance terms
  logic [VAL_W-1:0]   s1_under_r;
  sel_t               s1_sel_r;
  logic [7:0]         s1_b_r;
  logic [10:0]        s1_c_r;
  logic signed [12:0] cx_diff;
  logic [12:0]        cx_abs;

  assign cx_diff = c_r - $signed({3'b000, in_pix.dist_sq});
  assign cx_abs  = cx_diff[12] ? 13'(-cx_diff) : 13'(cx_diff);

  always_ff @(posedge clk) begin
    if (en[ST_S1]) begin
      s1_under_r <= in_pix.under_value;
      if (in_pix.dist_sq <= {2'b00, radius_sq_r}) begin
        s1_sel_r <= SEL_PEAK;
      end else if (in_pix.dist_sq >= EDGE_SQ) begin
        s1_sel_r <= SEL_ZERO;
      end else begin
        s1_sel_r <= SEL_CURVE;
      end
      s1_b_r <= 8'(EDGE_SQ - in_pix.dist_sq);
      s1_c_r <= cx_abs[10:0];
    end
  end

  // s2: numerator partial and denominator
  logic [VAL_W-1:0] s2_under_r;
  sel_t             s2_sel_r;
  logic [7:0]       s2_b_r;
  logic [22:0]      s2_num_r;
  logic [DEN_W-1:0] s2_den_r;

  always_ff @(posedge clk) begin
    if (en[ST_S2]) begin
      s2_under_r <= s1_under_r;
      s2_sel_r   <= s1_sel_r;
      s2_b_r     <= s1_b_r;
      s2_num_r   <= 23'(peak_r) * 23'(a_r);
      s2_den_r   <= DEN_W'(s1_c_r) * DEN_W'(d_r);
    end
  end

  // s3: full numerator
  logic [VAL_W-1:0] s3_under_r;
  sel_t             s3_sel_r;
  logic [NUM_W-1:0] s3_num_r;
  logic [DEN_W-1:0] s3_den_r;

  always_ff @(posedge clk) begin
    if (en[ST_S3]) begin
      s3_under_r <= s2_under_r;
      s3_sel_r   <= s2_sel_r;
      s3_num_r   <= NUM_W'(s2_num_r) * NUM_W'(s2_b_r);
      s3_den_r   <= s2_den_r;
    end
  end

  // s4 and divider: saturation test, then one quotient bit per stage
  logic [NUM_W-1:0]    rem_r [0:DIV_BITS];
  logic [DEN_W-1:0]    dden_r [0:DIV_BITS];
  logic [DIV_BITS-1:0] dq_r [0:DIV_BITS];
  logic [VAL_W-1:0]    dund_r [0:DIV_BITS];
  sel_t                dsel_r [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (en[ST_S4]) begin
      rem_r[0]  <= s3_num_r;
      dden_r[0] <= s3_den_r;
      dq_r[0]   <= '0;
      dund_r[0] <= s3_under_r;
      if (s3_sel_r == SEL_CURVE && s3_num_r >= {s3_den_r, 12'b0}) begin
        dsel_r[0] <= SEL_SAT;
      end else begin
        dsel_r[0] <= s3_sel_r;
      end
    end
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int K = DIV_BITS - 1 - j;
    logic [NUM_W-1:0] sub;
    assign sub = NUM_W'(dden_r[j]) << K;
    always_ff @(posedge clk) begin
      if (en[ST_S4 + 1 + j]) begin
        dden_r[j+1] <= dden_r[j];
        dund_r[j+1] <= dund_r[j];
        dsel_r[j+1] <= dsel_r[j];
        if (rem_r[j] >= sub) begin
          rem_r[j+1]   <= rem_r[j] - sub;
          dq_r[j+1]    <= dq_r[j] | (DIV_BITS'(1) << K);
        end else begin
          rem_r[j+1]   <= rem_r[j];
          dq_r[j+1]    <= dq_r[j];
        end
      end
    end
  end

  // v: falloff value
  logic [VAL_W-1:0] v_val_r, v_under_r;

  always_ff @(posedge clk) begin
    if (en[ST_V]) begin
      v_under_r <= dund_r[DIV_BITS];
      case (dsel_r[DIV_BITS])
        SEL_PEAK:  v_val_r <= peak_r;
        SEL_ZERO:  v_val_r <= '0;
        SEL_SAT:   v_val_r <= CEIL_VAL;
        SEL_CURVE: v_val_r <= dq_r[DIV_BITS];
        default:   v_val_r <= '0;
      endcase
    end
  end

  // blend stages
  logic [VAL_W-1:0] b1_val_r, b1_under_r, b2_val_r, b2_under_r;
  logic [VAL_W-1:0] b3_val_r, b3_under_r, b4_val_r, b4_under_r;
  logic [23:0]      b1_p_r;
  logic             b1_neg_r, b2_neg_r, b3_neg_r, b4_neg_r;
  logic [8:0]       b1_mag_r, gmag;
  logic [31:0]      b2_x_r;
  logic [19:0]      b3_h_r;
  logic [20:0]      b3_s_r, b4_q_r;
  logic [32:0]      bx_prod;
  logic [12:0]      b4_low;
  logic signed [22:0] blend_sum;

  assign gmag    = blend_gain_r[8] ? 9'(-blend_gain_r) : 9'(blend_gain_r);
  assign bx_prod = 33'(b1_p_r) * 33'(b1_mag_r);
  assign b4_low  = 13'(b3_s_r[20:12]) + 13'(b3_s_r[11:0]);
  assign blend_sum = b4_neg_r
      ? $signed({10'b0, 13'(b4_val_r) + 13'(b4_under_r)}) - $signed({2'b00, b4_q_r})
      : $signed({10'b0, 13'(b4_val_r) + 13'(b4_under_r)}) + $signed({2'b00, b4_q_r});

  always_ff @(posedge clk) begin
    if (en[ST_B1]) begin
      b1_val_r   <= v_val_r;
      b1_under_r <= v_under_r;
      b1_p_r     <= 24'(v_val_r) * 24'(v_under_r);
      b1_neg_r   <= blend_gain_r[8];
      b1_mag_r   <= gmag;
    end
    if (en[ST_B2]) begin
      b2_val_r   <= b1_val_r;
      b2_under_r <= b1_under_r;
      b2_neg_r   <= b1_neg_r;
      b2_x_r     <= bx_prod[31:0];
    end
    if (en[ST_B3]) begin
      b3_val_r   <= b2_val_r;
      b3_under_r <= b2_under_r;
      b3_neg_r   <= b2_neg_r;
      b3_h_r     <= b2_x_r[31:12];
      b3_s_r     <= 21'(b2_x_r[31:12]) + 21'(b2_x_r[11:0]);
    end
    if (en[ST_B4]) begin
      b4_val_r   <= b3_val_r;
      b4_under_r <= b3_under_r;
      b4_neg_r   <= b3_neg_r;
      b4_q_r     <= 21'(b3_h_r) + 21'(b3_s_r[20:12])
                  + ((b4_low >= 13'(CEIL_VAL)) ? 21'd1 : 21'd0);
    end
  end

  // output register
  logic [VAL_W-1:0] out_fall_r, out_blend_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_fall_r <= b4_val_r;
      if (blend_sum < 0) begin
        out_blend_r <= '0;
      end else if (blend_sum > $signed({11'b0, CEIL_VAL})) begin
        out_blend_r <= CEIL_VAL;
      end else begin
        out_blend_r <= blend_sum[VAL_W-1:0];
      end
    end
  end

  assign out_pix.valid         = vld_r[NST-1];
  assign out_pix.falloff_value = out_fall_r;
  assign out_pix.blended_value = out_blend_r;

  // checks
  a_no_beat_while_settling: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> settle_r == 2'd0)
    else $error("input beat taken while derived terms settle");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr.valid |=> !in_pix.ready)
    else $error("input ready right after a register write");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_V - 1] && dsel_r[DIV_BITS] == SEL_CURVE |->
      rem_r[DIV_BITS] < NUM_W'(dden_r[DIV_BITS]))
    else $error("divider remainder not below divisor");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    en[ST_V] && vld_r[ST_V - 1] && dsel_r[DIV_BITS] == SEL_SAT |=> v_val_r == CEIL_VAL)
    else $error("saturated curve not at ceiling");

endmodule
